/* design/mpa_pkg.sv */
`default_nettype none
package mpa_pkg;

    localparam int POOL_REG_W = 4;
    localparam int SIDE_REG_W = 8;
    localparam int MAPS_REG_W = 9;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_SIDE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_MAPS  = 2'd2;

    localparam int ARG_W  = 3;
    localparam int OROW_W = 7;
    localparam int OCOL_W = 7;
    localparam int MAP_W  = 8;

    // window flags for the sample at the current stream position
    typedef struct packed {
        logic in_span;
        logic first;
        logic last_win;
        logic last_map;
    } t_win_ctl;

endpackage
`default_nettype wire

/* design/max_pool_with_argmax.sv */
// a window result goes from stage 1 to the output register after its final word is accepted
// throughput: 1 word per cycle unless a stalled output holds stage 1; the line store is read
// on accept and written back as stage 1 advances, bypassed when neighbouring words share a column
// reset: position counters cleared, pool_size 2, in_side 28, num_maps 1;
// the line store is not cleared, each window writes its entry first
`default_nettype none
module max_pool_with_argmax #(
    parameter int MAX_SIDE    = 128,
    parameter int MAX_POOL    = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [mpa_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [mpa_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic                                  i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    // sample
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      i_s_axis_tdata,
    output logic                                       o_m_axis_tvalid,
    input  wire logic                                  i_m_axis_tready,
    // max_value, arg_row, arg_col, out_row, out_col, map_index
    output logic [((SAMPLE_BITS+28+7)/8)*8-1:0]        o_m_axis_tdata,
    // last_in_map
    output logic                                       o_m_axis_tlast
);
    import mpa_pkg::*;

    localparam int IW    = $clog2(MAX_SIDE);
    localparam int PW    = $clog2(MAX_POOL);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int PV    = $clog2(MAX_POOL + 1);
    localparam int CPW   = (PV > POOL_REG_W) ? PV : POOL_REG_W;
    localparam int CSW   = (SW > SIDE_REG_W) ? SW : SIDE_REG_W;
    localparam int OUT_W = SAMPLE_BITS + 2 * ARG_W + OROW_W + OCOL_W + MAP_W;
    localparam int OUT_B = ((SAMPLE_BITS + 28 + 7) / 8) * 8;

    logic [POOL_REG_W-1:0] r_pool;
    logic [SIDE_REG_W-1:0] r_side;
    logic [MAPS_REG_W-1:0] r_maps;

    logic [CPW-1:0]        pool_z;
    logic [CSW-1:0]        side_z;
    logic [PV-1:0]         p_eff;
    logic [SW-1:0]         side_eff;
    logic [MAPS_REG_W-1:0] maps_eff;
    logic                  restart, acc, can_take;

    t_win_ctl          ctl;
    logic [IW-1:0]     oc, orow;
    logic [PW-1:0]     wr, wc;
    logic [MAP_W-1:0]  map_cur;

    logic [SAMPLE_BITS-1:0] res_max;
    logic [ARG_W-1:0]       res_ar, res_ac;
    logic [OROW_W-1:0]      res_orow;
    logic [OCOL_W-1:0]      res_oc;
    logic [MAP_W-1:0]       res_map;

    always_comb begin
        pool_z = CPW'(r_pool);
        side_z = CSW'(r_side);
        priority if (pool_z == '0) begin
            p_eff = PV'(1);
        end else if (pool_z > CPW'(MAX_POOL)) begin
            p_eff = PV'(MAX_POOL);
        end else begin
            p_eff = PV'(pool_z);
        end
        priority if (side_z == '0) begin
            side_eff = SW'(1);
        end else if (side_z > CSW'(MAX_SIDE)) begin
            side_eff = SW'(MAX_SIDE);
        end else begin
            side_eff = SW'(side_z);
        end
        priority if (r_maps == '0) begin
            maps_eff = MAPS_REG_W'(1);
        end else if (r_maps > MAPS_REG_W'(256)) begin
            maps_eff = MAPS_REG_W'(256);
        end else begin
            maps_eff = r_maps;
        end
        restart = i_cfg_we && ((i_cfg_index == REG_POOL_SIZE) ||
                               (i_cfg_index == REG_IN_SIDE) ||
                               (i_cfg_index == REG_NUM_MAPS));
        acc = i_s_axis_tvalid && can_take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= POOL_REG_W'(2);
            r_side <= SIDE_REG_W'(28);
            r_maps <= MAPS_REG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_POOL_SIZE: r_pool <= i_cfg_data[POOL_REG_W-1:0];
                REG_IN_SIDE:   r_side <= i_cfg_data[SIDE_REG_W-1:0];
                REG_NUM_MAPS:  r_maps <= i_cfg_data[MAPS_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mpa_pos #(
        .MAX_SIDE (MAX_SIDE),
        .MAX_POOL (MAX_POOL)
    ) u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_restart (restart),
        .i_p       (p_eff),
        .i_side    (side_eff),
        .i_maps    (maps_eff),
        .o_ctl     (ctl),
        .o_oc      (oc),
        .o_orow    (orow),
        .o_wr      (wr),
        .o_wc      (wc),
        .o_map     (map_cur)
    );

    mpa_rmw #(
        .MAX_SIDE    (MAX_SIDE),
        .MAX_POOL    (MAX_POOL),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rmw (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .o_can_take  (can_take),
        .i_sample    (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_ctl       (ctl),
        .i_oc        (oc),
        .i_orow      (orow),
        .i_wr        (wr),
        .i_wc        (wc),
        .i_map       (map_cur),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_max       (res_max),
        .o_arg_row   (res_ar),
        .o_arg_col   (res_ac),
        .o_out_row   (res_orow),
        .o_out_col   (res_oc),
        .o_map_index (res_map),
        .o_last      (o_m_axis_tlast)
    );

    assign o_s_axis_tready = can_take;

    logic [OUT_W-1:0] res_packed;
    assign res_packed     = {res_map, res_oc, res_orow, res_ac, res_ar, res_max};
    assign o_m_axis_tdata = OUT_B'(res_packed);

endmodule
`default_nettype wire

/* design/mpa_pos.sv */
`default_nettype none
module mpa_pos #(
    parameter int MAX_SIDE = 128,
    parameter int MAX_POOL = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_acc,
    input  wire logic                                i_restart,
    input  wire logic [$clog2(MAX_POOL+1)-1:0]       i_p,
    input  wire logic [$clog2(MAX_SIDE+1)-1:0]       i_side,
    input  wire logic [mpa_pkg::MAPS_REG_W-1:0]      i_maps,
    output mpa_pkg::t_win_ctl                        o_ctl,
    output logic [$clog2(MAX_SIDE)-1:0]              o_oc,
    output logic [$clog2(MAX_SIDE)-1:0]              o_orow,
    output logic [$clog2(MAX_POOL)-1:0]              o_wr,
    output logic [$clog2(MAX_POOL)-1:0]              o_wc,
    output logic [mpa_pkg::MAP_W-1:0]                o_map
);
    import mpa_pkg::*;

    localparam int IW = $clog2(MAX_SIDE);
    localparam int PW = $clog2(MAX_POOL);
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int PV = $clog2(MAX_POOL + 1);
    localparam int ZW = ((SW > PV) ? SW : PV) + 2;

    logic [IW-1:0]    r_col, n_col, r_row, n_row;
    logic [IW-1:0]    r_wsc, n_wsc, r_wsr, n_wsr;
    logic [IW-1:0]    r_oc, n_oc, r_orow, n_orow;
    logic [PW-1:0]    r_wc, n_wc, r_wr, n_wr;
    logic [MAP_W-1:0] r_map, n_map;

    logic [ZW-1:0] side_z, p_z;
    logic          col_end, row_end, map_end, wc_end, wr_end;
    logic          col_in, row_in, last_col, last_row;

    always_comb begin
        side_z   = ZW'(i_side);
        p_z      = ZW'(i_p);
        col_end  = (ZW'(r_col) + ZW'(1)) == side_z;
        row_end  = (ZW'(r_row) + ZW'(1)) == side_z;
        map_end  = (MAPS_REG_W'(r_map) + MAPS_REG_W'(1)) == i_maps;
        wc_end   = (ZW'(r_wc) + ZW'(1)) == p_z;
        wr_end   = (ZW'(r_wr) + ZW'(1)) == p_z;
        // a window counts only if it closes inside the map
        col_in   = (ZW'(r_wsc) + p_z) <= side_z;
        row_in   = (ZW'(r_wsr) + p_z) <= side_z;
        last_col = (ZW'(r_wsc) + p_z + p_z) > side_z;
        last_row = (ZW'(r_wsr) + p_z + p_z) > side_z;

        o_ctl.in_span  = col_in && row_in;
        o_ctl.first    = (r_wc == '0) && (r_wr == '0);
        o_ctl.last_win = wc_end && wr_end;
        o_ctl.last_map = last_col && last_row;
        o_oc   = r_oc;
        o_orow = r_orow;
        o_wr   = r_wr;
        o_wc   = r_wc;
        o_map  = r_map;
    end

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_wsc  = r_wsc;
        n_wsr  = r_wsr;
        n_oc   = r_oc;
        n_orow = r_orow;
        n_wc   = r_wc;
        n_wr   = r_wr;
        n_map  = r_map;
        if (i_restart) begin
            n_col  = '0;
            n_row  = '0;
            n_wsc  = '0;
            n_wsr  = '0;
            n_oc   = '0;
            n_orow = '0;
            n_wc   = '0;
            n_wr   = '0;
            n_map  = '0;
        end else if (i_acc) begin
            if (col_end) begin
                n_col = '0;
                n_wsc = '0;
                n_oc  = '0;
                n_wc  = '0;
                if (row_end) begin
                    n_row  = '0;
                    n_wsr  = '0;
                    n_orow = '0;
                    n_wr   = '0;
                    n_map  = map_end ? '0 : r_map + MAP_W'(1);
                end else begin
                    n_row = r_row + IW'(1);
                    if (wr_end) begin
                        n_wr   = '0;
                        n_orow = r_orow + IW'(1);
                        n_wsr  = r_wsr + IW'(i_p);
                    end else begin
                        n_wr = r_wr + PW'(1);
                    end
                end
            end else begin
                n_col = r_col + IW'(1);
                if (wc_end) begin
                    n_wc  = '0;
                    n_oc  = r_oc + IW'(1);
                    n_wsc = r_wsc + IW'(i_p);
                end else begin
                    n_wc = r_wc + PW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_wsc  <= '0;
            r_wsr  <= '0;
            r_oc   <= '0;
            r_orow <= '0;
            r_wc   <= '0;
            r_wr   <= '0;
            r_map  <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_wsc  <= n_wsc;
            r_wsr  <= n_wsr;
            r_oc   <= n_oc;
            r_orow <= n_orow;
            r_wc   <= n_wc;
            r_wr   <= n_wr;
            r_map  <= n_map;
        end
    end

endmodule
`default_nettype wire

/* design/mpa_rmw.sv */
`default_nettype none
module mpa_rmw #(
    parameter int MAX_SIDE    = 128,
    parameter int MAX_POOL    = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_acc,
    output logic                                 o_can_take,
    input  wire logic [SAMPLE_BITS-1:0]          i_sample,
    input  wire mpa_pkg::t_win_ctl               i_ctl,
    input  wire logic [$clog2(MAX_SIDE)-1:0]     i_oc,
    input  wire logic [$clog2(MAX_SIDE)-1:0]     i_orow,
    input  wire logic [$clog2(MAX_POOL)-1:0]     i_wr,
    input  wire logic [$clog2(MAX_POOL)-1:0]     i_wc,
    input  wire logic [mpa_pkg::MAP_W-1:0]       i_map,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [SAMPLE_BITS-1:0]               o_max,
    output logic [mpa_pkg::ARG_W-1:0]            o_arg_row,
    output logic [mpa_pkg::ARG_W-1:0]            o_arg_col,
    output logic [mpa_pkg::OROW_W-1:0]           o_out_row,
    output logic [mpa_pkg::OCOL_W-1:0]           o_out_col,
    output logic [mpa_pkg::MAP_W-1:0]            o_map_index,
    output logic                                 o_last
);
    import mpa_pkg::*;

    localparam int IW = $clog2(MAX_SIDE);
    localparam int PW = $clog2(MAX_POOL);
    localparam int EW = SAMPLE_BITS + 2 * PW;

    // line store entry: {max, row offset, col offset}
    logic [EW-1:0] mem_line [MAX_SIDE];

    logic [EW-1:0]          r_rd_q, r_byp_q;
    logic                   r_byp;
    logic                   r_s1_vld;
    t_win_ctl               r_s1_ctl;
    logic [SAMPLE_BITS-1:0] r_s1_sample;
    logic [IW-1:0]          r_s1_oc, r_s1_orow;
    logic [PW-1:0]          r_s1_wr, r_s1_wc;
    logic [MAP_W-1:0]       r_s1_map;

    logic                   r_o_vld;
    logic [SAMPLE_BITS-1:0] r_o_max;
    logic [ARG_W-1:0]       r_o_ar, r_o_ac;
    logic [OROW_W-1:0]      r_o_orow;
    logic [OCOL_W-1:0]      r_o_oc;
    logic [MAP_W-1:0]       r_o_map;
    logic                   r_o_last;

    logic [EW-1:0]          old_e, new_e;
    logic [SAMPLE_BITS-1:0] old_max;
    logic                   emit, s1_adv, wr_en;

    always_comb begin
        old_e   = r_byp ? r_byp_q : r_rd_q;
        old_max = old_e[EW-1 -: SAMPLE_BITS];
        if (r_s1_ctl.first) begin
            new_e = {r_s1_sample, {(2 * PW){1'b0}}};
        end else if ($signed(r_s1_sample) > $signed(old_max)) begin
            new_e = {r_s1_sample, r_s1_wr, r_s1_wc};
        end else begin
            new_e = old_e;
        end
        emit       = r_s1_ctl.in_span && r_s1_ctl.last_win;
        s1_adv     = r_s1_vld && (!emit || !r_o_vld || i_ready);
        wr_en      = s1_adv && r_s1_ctl.in_span;
        o_can_take = !r_s1_vld || s1_adv;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_line[r_s1_oc] <= new_e;
        end
        if (i_acc) begin
            r_rd_q  <= mem_line[i_oc];
            // entry being written back at this edge: take the new value
            r_byp   <= wr_en && (r_s1_oc == i_oc);
            r_byp_q <= new_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_can_take) begin
            r_s1_vld <= i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_ctl    <= i_ctl;
            r_s1_sample <= i_sample;
            r_s1_oc     <= i_oc;
            r_s1_orow   <= i_orow;
            r_s1_wr     <= i_wr;
            r_s1_wc     <= i_wc;
            r_s1_map    <= i_map;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (s1_adv && emit) begin
            r_o_vld <= 1'b1;
        end else if (i_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && emit) begin
            r_o_max  <= new_e[EW-1 -: SAMPLE_BITS];
            r_o_ar   <= ARG_W'(new_e[2*PW-1 -: PW]);
            r_o_ac   <= ARG_W'(new_e[PW-1:0]);
            r_o_orow <= OROW_W'(r_s1_orow);
            r_o_oc   <= OCOL_W'(r_s1_oc);
            r_o_map  <= r_s1_map;
            r_o_last <= r_s1_ctl.last_map;
        end
    end

    assign o_valid     = r_o_vld;
    assign o_max       = r_o_max;
    assign o_arg_row   = r_o_ar;
    assign o_arg_col   = r_o_ac;
    assign o_out_row   = r_o_orow;
    assign o_out_col   = r_o_oc;
    assign o_map_index = r_o_map;
    assign o_last      = r_o_last;

endmodule
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import mpa_pkg::*;

    localparam int SAMPLE_W     = 16;
    localparam int IN_W         = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_W        = ((SAMPLE_W + 28 + 7) / 8) * 8;
    localparam int LINE_DEPTH   = 128;
    localparam int POOL_LIMIT   = 8;
    localparam int MAPS_LIMIT   = 256;
    localparam int ARGR_LO      = SAMPLE_W;
    localparam int ARGC_LO      = ARGR_LO + ARG_W;
    localparam int OROW_LO      = ARGC_LO + ARG_W;
    localparam int OCOL_LO      = OROW_LO + OROW_W;
    localparam int MAP_LO       = OCOL_LO + OCOL_W;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_SAMPLES = 90;
    localparam int PHASE_CAP    = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_CAP   = 40;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic signed [SAMPLE_W-1:0] max_value;
        logic [ARG_W-1:0]           arg_row;
        logic [ARG_W-1:0]           arg_col;
        logic [OROW_W-1:0]          out_row;
        logic [OCOL_W-1:0]          out_col;
        logic [MAP_W-1:0]           map_index;
        logic                       last_in_map;
    } t_pooled;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_W-1:0]       i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    max_pool_with_argmax dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the block: registers, stream position and line store
    int unsigned pool_reg, side_reg, maps_reg;
    int unsigned pos_col, pos_row, pos_map;
    logic signed [SAMPLE_W-1:0] line_max [LINE_DEPTH];
    logic [ARG_W-1:0]           line_arg_row [LINE_DEPTH];
    logic [ARG_W-1:0]           line_arg_col [LINE_DEPTH];
    t_pooled                    pooled_q [$];

    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int unsigned rx_gap = 0;
    int unsigned hold_req_seq = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    function automatic int unsigned clamp_reg(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        if (err_count < REPORT_CAP)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        unique case (idx)
            REG_POOL_SIZE: pool_reg = val & 'hF;
            REG_IN_SIDE:   side_reg = val & 'hFF;
            REG_NUM_MAPS:  maps_reg = val & 'h1FF;
            default:       return;
        endcase
        pos_col = 0;
        pos_row = 0;
        pos_map = 0;
    endtask

    task automatic track_sample(input logic signed [SAMPLE_W-1:0] s);
        int unsigned p, side, maps, nwin, span, oc, orow, wr, wc;
        t_pooled w;
        p    = clamp_reg(pool_reg, 1, POOL_LIMIT);
        side = clamp_reg(side_reg, 1, LINE_DEPTH);
        maps = clamp_reg(maps_reg, 1, MAPS_LIMIT);
        nwin = side / p;
        span = nwin * p;
        if (pos_col >= side) pos_col = 0;
        if (pos_row >= side) pos_row = 0;
        if (pos_map >= maps) pos_map = 0;
        if (pos_row < span && pos_col < span) begin
            oc   = pos_col / p;
            orow = pos_row / p;
            wr   = pos_row % p;
            wc   = pos_col % p;
            if (wr == 0 && wc == 0) begin
                line_max[oc]     = s;
                line_arg_row[oc] = '0;
                line_arg_col[oc] = '0;
            end else if (s > line_max[oc]) begin
                line_max[oc]     = s;
                line_arg_row[oc] = wr[ARG_W-1:0];
                line_arg_col[oc] = wc[ARG_W-1:0];
            end
            if (wr == p - 1 && wc == p - 1) begin
                w.max_value   = line_max[oc];
                w.arg_row     = line_arg_row[oc];
                w.arg_col     = line_arg_col[oc];
                w.out_row     = orow[OROW_W-1:0];
                w.out_col     = oc[OCOL_W-1:0];
                w.map_index   = pos_map[MAP_W-1:0];
                w.last_in_map = (orow == nwin - 1 && oc == nwin - 1);
                pooled_q.push_back(w);
            end
        end
        pos_col++;
        if (pos_col >= side) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= side) begin
                pos_row = 0;
                pos_map++;
                if (pos_map >= maps) pos_map = 0;
            end
        end
    endtask

    task automatic check_window();
        t_pooled w;
        if (pooled_q.size() == 0) begin
            report("window with none pending, max_value",
                   $signed(o_m_axis_tdata[SAMPLE_W-1:0]), 0);
            return;
        end
        w = pooled_q.pop_front();
        if ($signed(o_m_axis_tdata[SAMPLE_W-1:0]) !== w.max_value)
            report("max_value", $signed(o_m_axis_tdata[SAMPLE_W-1:0]), w.max_value);
        if (o_m_axis_tdata[ARGR_LO +: ARG_W] !== w.arg_row)
            report("arg_row", o_m_axis_tdata[ARGR_LO +: ARG_W], w.arg_row);
        if (o_m_axis_tdata[ARGC_LO +: ARG_W] !== w.arg_col)
            report("arg_col", o_m_axis_tdata[ARGC_LO +: ARG_W], w.arg_col);
        if (o_m_axis_tdata[OROW_LO +: OROW_W] !== w.out_row)
            report("out_row", o_m_axis_tdata[OROW_LO +: OROW_W], w.out_row);
        if (o_m_axis_tdata[OCOL_LO +: OCOL_W] !== w.out_col)
            report("out_col", o_m_axis_tdata[OCOL_LO +: OCOL_W], w.out_col);
        if (o_m_axis_tdata[MAP_LO +: MAP_W] !== w.map_index)
            report("map_index", o_m_axis_tdata[MAP_LO +: MAP_W], w.map_index);
        if (o_m_axis_tlast !== w.last_in_map)
            report("last_in_map", o_m_axis_tlast, w.last_in_map);
    endtask

    // long receiver hold-off, armed from the tests
    always @(posedge i_clk) begin
        if (hold_req_seq != hold_seen) begin
            hold_seen <= hold_req_seq;
            hold_left <= LONG_HOLD;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                check_window();
                rx_gap = rx_idle_on ? $urandom_range(0, 16) : 0;
            end else if (rx_gap != 0) begin
                rx_gap--;
            end
            i_m_axis_tready <= (rx_gap == 0) && (hold_left == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        do @(posedge i_clk); while (!o_s_axis_tready);
        track_sample(s);
    endtask

    // stop offering, let every pending window out, then cover windowless words
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (pooled_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        apply_reg(idx, val);
    endtask

    task automatic set_shape(input int unsigned pool, input int unsigned side,
                             input int unsigned maps);
        write_reg(REG_POOL_SIZE, pool);
        write_reg(REG_IN_SIDE, side);
        write_reg(REG_NUM_MAPS, maps);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        unique case ($urandom_range(0, 3))
            0: return SAMPLE_W'($urandom_range(0, 4) - 2);    // many ties
            1: unique case ($urandom_range(0, 3))
                   0: return 16'sh7FFF;
                   1: return 16'sh8000;
                   2: return 16'sh0000;
                   default: return 16'shFFFF;
               endcase
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_random(input int unsigned n);
        repeat (n) send_sample(draw_sample());
    endtask

    // reset values: pool 2 over a 28 wide map, first two rows only
    task automatic test_reset_shape();
        send_random(56);
    endtask

    task automatic test_window_extremes();
        logic signed [SAMPLE_W-1:0] pix [16] = '{
            -16'sd32768, -16'sd32768, 16'sd5,     16'sd5,
            -16'sd32768, -16'sd32768, 16'sd5,     16'sd32767,
            16'sd32767,  16'sd32767,  -16'sd2,    16'sd7,
            -16'sd1,     16'sd0,      16'sd7,     -16'sd3
        };
        set_shape(2, 4, 1);
        foreach (pix[i]) send_sample(pix[i]);
    endtask

    // pool above the limit acts as 8; the ninth row and column are ragged
    task automatic test_wide_pool();
        set_shape(15, 9, 1);
        for (int r = 0; r < 9; r++)
            for (int c = 0; c < 9; c++)
                if (r == 8 || c == 8) send_sample(16'sh7FFF);
                else if (r == 7 && c == 7) send_sample(16'sd1000);
                else send_sample(-16'sd100);
    endtask

    task automatic test_zero_pool();
        set_shape(0, 3, 2);
        send_random(18);
    endtask

    task automatic test_window_too_big();
        set_shape(5, 4, 1);
        send_random(16);
    endtask

    task automatic test_side_clamp();
        set_shape(1, 255, 1);
        send_random(130);
        set_shape(1, 0, 0);
        send_random(3);
    endtask

    task automatic test_map_wrap();
        set_shape(1, 1, 511);
        send_random(260);
    endtask

    // a write to the spare index must not restart the stream
    task automatic test_spare_index();
        set_shape(2, 4, 1);
        send_random(8);
        write_reg(REG_SPARE, 'h1AB);
        send_random(8);
    endtask

    task automatic test_backpressure();
        set_shape(1, 8, 1);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_req_seq <= hold_req_seq + 1;
        send_random(64);
        settle();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_streams();
        int unsigned sent, pool_v, side_v, maps_v, total;
        sent = 0;
        while (sent < RANDOM_SAMPLES) begin
            pool_v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
            side_v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 10);
            maps_v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 3);
            set_shape(pool_v, side_v, maps_v);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            total = clamp_reg(maps_v, 1, MAPS_LIMIT) * clamp_reg(side_v, 1, LINE_DEPTH)
                    * clamp_reg(side_v, 1, LINE_DEPTH);
            if (total > PHASE_CAP) total = $urandom_range(10, PHASE_CAP);
            // now and then a stream cut short
            if ($urandom_range(0, 5) == 0) total = $urandom_range(1, total);
            if (total > RANDOM_SAMPLES - sent) total = RANDOM_SAMPLES - sent;
            send_random(total);
            sent += total;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= REG_POOL_SIZE;
        i_cfg_data      <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        pool_reg = 2;
        side_reg = 28;
        maps_reg = 1;
        pos_col  = 0;
        pos_row  = 0;
        pos_map  = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_shape();
        test_window_extremes();
        test_wide_pool();
        test_zero_pool();
        test_window_too_big();
        test_side_clamp();
        test_map_wrap();
        test_spare_index();
        test_backpressure();
        test_random_streams();
        settle();

        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire
